// ----- design/ppdw_pkg.sv -----
// Shared constants, codes and control types of the per-peer delivery window tracker.
`timescale 1ns / 1ps

package ppdw_pkg;

	// Geometry of the tracker
	localparam int PEERS  = 128;
	localparam int WINDOW = 64;

	// Field widths of the words
	localparam int PEER_W = 7;
	localparam int SEQ_W  = 32;
	localparam int ADV_W  = 7;
	localparam int STS_W  = 2;

	// Derived widths
	localparam int IDX_W      = $clog2(PEERS);
	localparam int BIT_W      = $clog2(WINDOW);
	localparam int ENTRY_W    = SEQ_W + WINDOW;
	localparam int S_TDATA_W  = ((PEER_W + SEQ_W + 7) / 8) * 8;
	localparam int M_TDATA_W  = ((SEQ_W + ADV_W + STS_W + 7) / 8) * 8;

	// Bits of the held map examined per scan step
	localparam int SCAN_W   = 8;
	localparam int SHIFT_W  = $clog2(SCAN_W + 1);

	// Outcome of one update
	typedef enum logic [STS_W-1:0] {
		ST_ADVANCED = 2'd0,
		ST_HELD     = 2'd1,
		ST_STALE    = 2'd2,
		ST_BEYOND   = 2'd3
	} status_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic capture;   // latch the input word and read the peer entry
		logic lookup;    // classify seq against the stored watermark
		logic scan;      // consume one step of consecutive held bits
		logic commit;    // write back the entry and load the result word
	} ctl_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic advance;   // seq equals the watermark
		logic scan_last; // the current scan step ends the run of held bits
		logic out_free;  // the output register can take a word this cycle
	} ctl_sts_t;

endpackage

// ----- design/ppdw_ctrl.sv -----
// Controller state machine of the per-peer delivery window tracker.
`timescale 1ns / 1ps

module ppdw_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  ppdw_pkg::ctl_sts_t sts,
	output ppdw_pkg::ctl_cmd_t cmd
);
	import ppdw_pkg::*;

	typedef enum logic [1:0] {
		IDLE,
		LOOKUP,
		SCAN,
		FINISH
	} state_t;

	state_t state_q;

	// Take a new word only when no update is in flight
	assign in_ready = (state_q == IDLE);

	// Decode commands from the current state
	always_comb begin
		cmd         = '0;
		cmd.capture = (state_q == IDLE) && in_valid;
		cmd.lookup  = (state_q == LOOKUP);
		cmd.scan    = (state_q == SCAN);
		cmd.commit  = (state_q == FINISH) && sts.out_free;
	end

	// Sequence one update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
		end else begin
			case (state_q)
				IDLE: begin
					if (in_valid) state_q <= LOOKUP;
				end
				LOOKUP: begin
					state_q <= sts.advance ? SCAN : FINISH;
				end
				SCAN: begin
					if (sts.scan_last) state_q <= FINISH;
				end
				FINISH: begin
					if (sts.out_free) state_q <= IDLE;
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

endmodule

// ----- design/ppdw_dpath.sv -----
// Datapath of the per-peer delivery window tracker: peer store, compare, scan and result register.
`timescale 1ns / 1ps

module ppdw_dpath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [ppdw_pkg::PEER_W-1:0]     in_peer,
	input  logic [ppdw_pkg::SEQ_W-1:0]      in_seq,
	input  ppdw_pkg::ctl_cmd_t              cmd,
	output ppdw_pkg::ctl_sts_t              sts,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [ppdw_pkg::SEQ_W-1:0]      out_next_expected,
	output logic [ppdw_pkg::ADV_W-1:0]      out_advanced_by,
	output ppdw_pkg::status_t               out_status
);
	import ppdw_pkg::*;

	// Peer store and per-entry valid bits
	logic [ENTRY_W-1:0] mem_q [PEERS];
	logic [PEERS-1:0]   vld_q;
	logic [ENTRY_W-1:0] rd_q;
	logic               rd_vld_q;

	// Working registers of the update in flight
	logic [IDX_W-1:0]   idx_q;
	logic               range_q;
	logic [SEQ_W-1:0]   seq_q;
	logic [SEQ_W-1:0]   wm_q;
	logic [WINDOW-1:0]  map_q;
	logic [ADV_W-1:0]   adv_q;
	status_t            sts_q;

	// Result register
	logic               out_valid_q;
	logic [SEQ_W-1:0]   out_wm_q;
	logic [ADV_W-1:0]   out_adv_q;
	status_t            out_sts_q;

	// Lookup logic
	logic [SEQ_W-1:0]   wm_cur;
	logic [WINDOW-1:0]  map_cur;
	logic [WINDOW-1:0]  map_upd;
	logic [SEQ_W-1:0]   diff;
	logic [SEQ_W-1:0]   diff_m1;
	logic               is_eq;
	logic               is_stale;
	logic               is_held;

	// Scan logic
	logic [SCAN_W-1:0]  low;
	logic [SHIFT_W-1:0] ones;
	logic [SHIFT_W-1:0] shamt;
	logic               last;

	logic [IDX_W-1:0]   in_idx;
	logic               in_range;

	assign in_idx   = IDX_W'(in_peer);
	assign in_range = (32'(in_peer) < 32'(PEERS));

	// Current entry, reset value where never written
	assign wm_cur  = rd_vld_q ? rd_q[SEQ_W-1:0] : '0;
	assign map_cur = rd_vld_q ? rd_q[ENTRY_W-1:SEQ_W] : '0;

	// Classify seq against the watermark
	assign diff     = seq_q - wm_cur;
	assign diff_m1  = diff - 32'd1;
	assign is_eq    = (diff == '0);
	assign is_stale = (seq_q < wm_cur);
	assign is_held  = (diff <= 32'(WINDOW));

	// Mark a held number in the map, keep it otherwise
	assign map_upd = (range_q && !is_eq && !is_stale && is_held) ?
	                 (map_cur | (WINDOW'(1) << diff_m1[BIT_W-1:0])) : map_cur;

	// Count consecutive held bits in the low slice of the map
	assign low = map_q[SCAN_W-1:0];
	always_comb begin
		logic stop;
		stop = 1'b0;
		ones = '0;
		for (int i = 0; i < SCAN_W; i++) begin
			if (!stop && low[i]) begin
				ones = ones + SHIFT_W'(1);
			end else begin
				stop = 1'b1;
			end
		end
	end

	assign last  = (ones != SHIFT_W'(SCAN_W));
	assign shamt = last ? (ones + SHIFT_W'(1)) : ones;

	assign sts.advance   = range_q && is_eq;
	assign sts.scan_last = last;
	assign sts.out_free  = !out_valid_q || out_ready;

	// Read the peer entry on capture and write it back on commit; its valid bit is read below
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			rd_q <= mem_q[in_idx];
		end
		if (cmd.commit && range_q) begin
			mem_q[idx_q] <= {map_q, wm_q + SEQ_W'(adv_q)};
		end
	end

	// Track written entries; reset clears them all at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (cmd.capture) rd_vld_q <= vld_q[in_idx];
			if (cmd.commit && range_q) vld_q[idx_q] <= 1'b1;
		end
	end

	// Working registers: capture, classify, scan
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			idx_q   <= in_idx;
			range_q <= in_range;
			seq_q   <= in_seq;
		end
		if (cmd.lookup) begin
			adv_q <= '0;
			map_q <= map_upd;
			wm_q  <= range_q ? wm_cur : '0;
			if (!range_q) begin
				sts_q <= ST_BEYOND;
			end else if (is_eq) begin
				sts_q <= ST_ADVANCED;
			end else if (is_stale) begin
				sts_q <= ST_STALE;
			end else if (is_held) begin
				sts_q <= ST_HELD;
			end else begin
				sts_q <= ST_BEYOND;
			end
		end
		if (cmd.scan) begin
			map_q <= map_q >> shamt;
			adv_q <= adv_q + ADV_W'(shamt);
		end
	end

	// Result register: load on commit, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_wm_q  <= wm_q + SEQ_W'(adv_q);
			out_adv_q <= adv_q;
			out_sts_q <= sts_q;
		end
	end

	assign out_valid         = out_valid_q;
	assign out_next_expected = out_wm_q;
	assign out_advanced_by   = out_adv_q;
	assign out_status        = out_sts_q;

endmodule

// ----- design/per_peer_delivery_window_tracker.sv -----
// Sequence: capture reads the peer entry, LOOKUP classifies seq against the watermark, SCAN
// runs only when the watermark advances and examines 8 held bits per scan step, and FINISH
// writes back the entry and loads the result word, waiting while the result register is full.
// One word at a time: s_tready stays low from acceptance until the entry is written back.
// Reset: arst_n clears the controller, result valid and all per-peer valid bits at once;
// every peer then reads as watermark zero with an empty held map, no clearing pass.
`timescale 1ns / 1ps

module per_peer_delivery_window_tracker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [ppdw_pkg::S_TDATA_W-1:0]   s_tdata,  // peer, seq
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [ppdw_pkg::M_TDATA_W-1:0]   m_tdata   // next_expected, advanced_by, status
);
	import ppdw_pkg::*;

	ctl_cmd_t           cmd;
	ctl_sts_t           sts;
	logic [SEQ_W-1:0]   next_expected;
	logic [ADV_W-1:0]   advanced_by;
	status_t            status;

	ppdw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ppdw_dpath u_dpath (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_peer           (s_tdata[PEER_W-1:0]),
		.in_seq            (s_tdata[PEER_W+SEQ_W-1:PEER_W]),
		.cmd               (cmd),
		.sts               (sts),
		.out_valid         (m_tvalid),
		.out_ready         (m_tready),
		.out_next_expected (next_expected),
		.out_advanced_by   (advanced_by),
		.out_status        (status)
	);

	// Pack the result word
	assign m_tdata = M_TDATA_W'({status, advanced_by, next_expected});

	// An accepted word blocks the input until its update completes
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while an update is in flight");

	// Only an in-order word moves the watermark
	a_adv_only_in_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (advanced_by != '0) |-> status == ST_ADVANCED)
		else $error("watermark moved on a non-advancing word");

	// An in-order word always moves the watermark by at least one
	a_adv_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && status == ST_ADVANCED |-> advanced_by != '0)
		else $error("in-order word did not advance the watermark");

	// The watermark never jumps past the window
	a_adv_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> 32'(advanced_by) <= 32'(WINDOW + 1))
		else $error("advance exceeds window");

endmodule

// ----- bench/tb_per_peer_delivery_window_tracker.sv -----
// Testbench for the per-peer delivery window tracker: stream stimulus, predictor and checker.
`timescale 1ns / 1ps

module tb_per_peer_delivery_window_tracker;

	import ppdw_pkg::*;

	// One result word split into its fields
	typedef struct {
		logic [SEQ_W-1:0] next_exp;
		logic [ADV_W-1:0] moved;
		status_t          sts;
	} window_result_t;

	// Per-peer watermark and held map, the results they imply, and the mismatch count
	class window_ledger;
		logic [SEQ_W-1:0]  mark [PEERS];
		logic [WINDOW-1:0] held [PEERS];
		window_result_t    pending_results [$];
		int                errors;

		function new();
			foreach (mark[i]) begin
				mark[i] = '0;
				held[i] = '0;
			end
			errors = 0;
		endfunction

		// Apply one accepted delivery to the peer record and queue its result
		function void note_delivery(logic [PEER_W-1:0] p, logic [SEQ_W-1:0] s);
			window_result_t    r;
			logic [SEQ_W-1:0]  wm;
			logic [WINDOW-1:0] map;
			logic [SEQ_W-1:0]  gap;
			int                run;
			wm  = mark[p];
			map = held[p];
			r.moved = '0;
			if (s == wm) begin
				// advance past the delivered number and every held one right after it
				run = 0;
				while (run < WINDOW && map[run])
					run++;
				map = (run + 1 >= WINDOW) ? '0 : (map >> (run + 1));
				r.moved = ADV_W'(run + 1);
				wm = wm + SEQ_W'(run + 1);
				r.sts = ST_ADVANCED;
			end else if (s < wm) begin
				r.sts = ST_STALE;
			end else begin
				gap = s - wm;
				if (gap <= WINDOW) begin
					map[gap - 1] = 1'b1;
					r.sts = ST_HELD;
				end else begin
					r.sts = ST_BEYOND;
				end
			end
			mark[p] = wm;
			held[p] = map;
			r.next_exp = wm;
			pending_results.push_back(r);
		endfunction

		// Print one mismatch line and count it
		task report_mismatch(string what, longint got, longint want);
			errors++;
			$display("%0t mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
		endtask

		// Compare one accepted result word with the oldest expectation
		task check_result(logic [M_TDATA_W-1:0] w);
			window_result_t r;
			logic [SEQ_W-1:0] got_exp;
			logic [ADV_W-1:0] got_moved;
			logic [STS_W-1:0] got_sts;
			got_exp   = w[SEQ_W-1:0];
			got_moved = w[SEQ_W+ADV_W-1:SEQ_W];
			got_sts   = w[SEQ_W+ADV_W+STS_W-1:SEQ_W+ADV_W];
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result word, next_expected", got_exp, -1);
			end else begin
				r = pending_results.pop_front();
				if (got_exp !== r.next_exp)
					report_mismatch("next_expected", got_exp, r.next_exp);
				if (got_moved !== r.moved)
					report_mismatch("advanced_by", got_moved, r.moved);
				if (got_sts !== r.sts)
					report_mismatch("status", got_sts, r.sts);
			end
		endtask
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;   // peer, seq
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;   // next_expected, advanced_by, status

	window_ledger book;
	bit           idle_on = 1'b1;
	int           sent = 0;

	per_peer_delivery_window_tracker DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	// Free-running clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Hard stop in case the block hangs
	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// Offer one delivery word, idling now and then, and record it once accepted
	task automatic send_delivery(input logic [PEER_W-1:0] p, input logic [SEQ_W-1:0] s);
		logic [S_TDATA_W-1:0] w;
		while (idle_on && $urandom_range(99) < 11) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		w = '0;
		w[PEER_W-1:0] = p;
		w[PEER_W+SEQ_W-1:PEER_W] = s;
		s_tvalid <= 1'b1;
		s_tdata  <= w;
		do @(posedge clk); while (!s_tready);
		book.note_delivery(p, s);
		sent++;
	endtask

	// Deliver the k numbers above the watermark in shuffled order, then the watermark itself
	task automatic fill_and_release(input logic [PEER_W-1:0] p, input int k);
		logic [SEQ_W-1:0] wm;
		logic [SEQ_W-1:0] order [$];
		logic [SEQ_W-1:0] tmp;
		int               j;
		wm = book.mark[p];
		for (int i = 1; i <= k; i++)
			order.push_back(wm + SEQ_W'(i));
		for (int i = k - 1; i > 0; i--) begin
			j = $urandom_range(i);
			tmp = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		foreach (order[i])
			send_delivery(p, order[i]);
		send_delivery(p, wm);
	endtask

	// One delivery aimed relative to the peer's watermark: in order, held, stale or beyond
	task automatic aimed_delivery(input logic [PEER_W-1:0] p);
		logic [SEQ_W-1:0] wm;
		int               pick;
		wm   = book.mark[p];
		pick = $urandom_range(99);
		if (pick < 35)
			send_delivery(p, wm);
		else if (pick < 75)
			send_delivery(p, wm + SEQ_W'($urandom_range(1, WINDOW)));
		else if (pick < 85 && wm != 0)
			send_delivery(p, wm - SEQ_W'($urandom_range(1, wm)));
		else if (pick < 93)
			send_delivery(p, wm + SEQ_W'(WINDOW + 1 + $urandom_range(0, 200)));
		else
			send_delivery(p, $urandom);
	endtask

	// Result side: check every accepted word, stall now and then
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				book.check_result(m_tdata);
			m_tready <= idle_on ? ($urandom_range(99) >= 11) : 1'b1;
		end
	end

	// Reset, directed cases, random traffic, drain
	initial begin
		logic [PEER_W-1:0] p;
		int                mode;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		book = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// in order, top of window, just beyond, lowest held, duplicate, stale, chained advance
		send_delivery(7'd0, 32'd0);
		send_delivery(7'd0, 32'd65);
		send_delivery(7'd0, 32'd66);
		send_delivery(7'd0, 32'd2);
		send_delivery(7'd0, 32'd2);
		send_delivery(7'd0, 32'd0);
		send_delivery(7'd0, 32'd1);
		send_delivery(7'd0, 32'hFFFF_FFFF);
		// gaps in the held map stop the advance
		send_delivery(7'd127, 32'd0);
		send_delivery(7'd127, 32'd5);
		send_delivery(7'd127, 32'd3);
		send_delivery(7'd127, 32'd1);
		send_delivery(7'd127, 32'd2);
		send_delivery(7'd127, 32'd4);
		send_delivery(7'd1, 32'h8000_0000);
		send_delivery(7'd64, 32'd0);
		send_delivery(7'd64, 32'd0);
		send_delivery(7'd85, 32'h5555_5555);
		send_delivery(7'd42, 32'hAAAA_AAAA);

		// random traffic, mostly on a few busy peers
		while (sent < 1450) begin
			idle_on = !(sent >= 500 && sent < 850);
			p = ($urandom_range(3) == 0) ? PEER_W'($urandom_range(PEERS - 1))
			                             : PEER_W'($urandom_range(3));
			mode = $urandom_range(99);
			if (mode < 12)
				fill_and_release(p, ($urandom_range(5) == 0) ? WINDOW : $urandom_range(1, 16));
			else if (mode < 85)
				aimed_delivery(p);
			else
				send_delivery(PEER_W'($urandom_range(PEERS - 1)), $urandom);
		end
		s_tvalid <= 1'b0;
		idle_on = 1'b1;

		// drain and let the tail settle
		while (book.pending_results.size() != 0)
			@(posedge clk);
		repeat (24) @(posedge clk);
		if (book.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
